>>> rtl/core/perspective_floor_row_vectors_defines.svh
// ----------------------------------------------------------------------------
// Perspective floor row vectors: assertion macros
// Shared property wrappers for the row vector pipeline checks.
// ----------------------------------------------------------------------------
`ifndef PERSPECTIVE_FLOOR_ROW_VECTORS_DEFINES_SVH
`define PERSPECTIVE_FLOOR_ROW_VECTORS_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PFRV_AST_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("pfrv same-cycle check failed");

// next-cycle implication, checked out of reset
`define PFRV_AST_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("pfrv next-cycle check failed");

`endif

>>> rtl/core/pfrv_pkg.sv
// ----------------------------------------------------------------------------
// pfrv_pkg
// Types, constants and helpers for the perspective floor row vector block.
// ----------------------------------------------------------------------------
`default_nettype none

package pfrv_pkg;

  localparam int ROWS        = 96;
  localparam int HEADER_ROWS = 3;
  localparam int RW          = $clog2(ROWS);   // row field width
  localparam int DW          = 22;             // divisor magnitude width
  localparam int QW          = 32;             // dividend / quotient width
  localparam int LANES       = 4;

  localparam logic [8:0]  QUARTER_TURN = 9'd128;
  localparam int          NEAR_SHIFT   = 10;       // 1024 = near-plane scale
  localparam logic signed [31:0] FAR_SCALE = 32'sd1016;  // 127 * 8
  localparam logic [15:0] HDR_START_U  = 16'h0000;
  localparam logic [15:0] HDR_START_V  = 16'hFFF8;
  localparam logic [15:0] HDR_STEP     = 16'h0000;

  typedef enum logic [2:0] {
    REG_TILT   = 3'd0,
    REG_TURN   = 3'd1,
    REG_POS_X  = 3'd2,
    REG_POS_Y  = 3'd3,
    REG_ZOOM   = 3'd4,
    REG_HEIGHT = 3'd5,
    REG_OFFSET = 3'd6
  } cfg_reg_t;

  localparam logic [8:0] QSINE [0:127] = '{
    9'd0,   9'd3,   9'd6,   9'd9,   9'd12,  9'd15,  9'd18,  9'd22,
    9'd25,  9'd28,  9'd31,  9'd34,  9'd37,  9'd40,  9'd43,  9'd47,
    9'd50,  9'd53,  9'd56,  9'd59,  9'd62,  9'd65,  9'd68,  9'd71,
    9'd74,  9'd77,  9'd80,  9'd83,  9'd86,  9'd89,  9'd92,  9'd95,
    9'd98,  9'd101, 9'd104, 9'd106, 9'd109, 9'd112, 9'd115, 9'd118,
    9'd121, 9'd123, 9'd126, 9'd129, 9'd132, 9'd134, 9'd137, 9'd140,
    9'd142, 9'd145, 9'd147, 9'd150, 9'd153, 9'd155, 9'd158, 9'd160,
    9'd162, 9'd165, 9'd167, 9'd170, 9'd172, 9'd174, 9'd177, 9'd179,
    9'd181, 9'd183, 9'd185, 9'd188, 9'd190, 9'd192, 9'd194, 9'd196,
    9'd198, 9'd200, 9'd202, 9'd204, 9'd206, 9'd208, 9'd209, 9'd211,
    9'd213, 9'd215, 9'd216, 9'd218, 9'd220, 9'd221, 9'd223, 9'd224,
    9'd226, 9'd227, 9'd229, 9'd230, 9'd231, 9'd233, 9'd234, 9'd235,
    9'd236, 9'd238, 9'd239, 9'd240, 9'd241, 9'd242, 9'd243, 9'd244,
    9'd245, 9'd246, 9'd247, 9'd247, 9'd248, 9'd249, 9'd250, 9'd250,
    9'd251, 9'd251, 9'd252, 9'd252, 9'd253, 9'd253, 9'd254, 9'd254,
    9'd254, 9'd255, 9'd255, 9'd255, 9'd255, 9'd255, 9'd255, 9'd256
  };

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QW-1:0] word;   // dividend bits out the top, quotient bits in
  } div_lane_t;

  typedef struct packed {
    logic          hdr;
    logic [DW-1:0] dabs;
    logic [LANES-1:0] neg;
    logic [15:0]   offu;
    logic [15:0]   offv;
  } div_ctl_t;

  function automatic logic signed [9:0] sine9(input logic [8:0] a);
    logic [6:0] t;
    logic [9:0] v;
    t = a[7] ? ~a[6:0] : a[6:0];
    v = {1'b0, QSINE[t]};
    return a[8] ? $signed(-v) : $signed(v);
  endfunction

  // one restoring division step
  function automatic div_lane_t div_step(input div_lane_t l, input logic [DW-1:0] dabs);
    logic [DW:0] trial;
    logic        ge;
    div_lane_t   r;
    trial  = {l.rem, l.word[QW-1]};
    ge     = trial >= {1'b0, dabs};
    r.rem  = ge ? DW'(trial - {1'b0, dabs}) : trial[DW-1:0];
    r.word = {l.word[QW-2:0], ge};
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/perspective_floor_row_vectors.sv
// ----------------------------------------------------------------------------
// perspective_floor_row_vectors
// Per-scanline start and step vectors for a rotated perspective floor.
// ----------------------------------------------------------------------------
//   channel  direction  handshake             payload
//   in       to block   in_valid / in_stall   row
//   out      from block out_valid / out_stall start_u start_v step_u step_v
//   cfg      to block   cfg_valid / cfg_ready cfg_index cfg_data
//
// One row per cycle while the output is not stalled; the pipeline is six
// arithmetic stages, 33 registers of the 32-step pipelined divider, output.
// Reset is synchronous, clears the valid bits and sets the config defaults.
// A stalled output freezes the whole pipeline, so in_stall follows it.
`default_nettype none

`include "perspective_floor_row_vectors_defines.svh"

module perspective_floor_row_vectors
  import pfrv_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [6:0]         row,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      start_u,
  output logic signed [15:0]      start_v,
  output logic signed [15:0]      step_u,
  output logic signed [15:0]      step_v,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  // configuration
  logic [8:0]         tilt_angle, turn_angle;
  logic [15:0]        pos_x, pos_y;
  logic signed [15:0] zoom, eye_height, eye_offset;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tilt_angle <= '0;
      turn_angle <= '0;
      pos_x      <= '0;
      pos_y      <= '0;
      zoom       <= '0;
      eye_height <= 16'sd128;
      eye_offset <= -16'sd64;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_TILT:   tilt_angle <= cfg_data[8:0];
        REG_TURN:   turn_angle <= cfg_data[8:0];
        REG_POS_X:  pos_x      <= cfg_data;
        REG_POS_Y:  pos_y      <= cfg_data;
        REG_ZOOM:   zoom       <= cfg_data;
        REG_HEIGHT: eye_height <= cfg_data;
        REG_OFFSET: eye_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: capture, angle lookups
  logic              s1_valid, s1_hdr;
  logic signed [7:0] s1_d;
  logic signed [9:0] s1_sx, s1_cx, s1_sz, s1_cz;
  logic signed [16:0] s1_hi;
  // stage 2: first products
  logic              s2_valid, s2_hdr;
  logic signed [7:0] s2_d;
  logic signed [9:0] s2_sz, s2_cz;
  logic signed [16:0] s2_hi;
  logic signed [19:0] s2_cxsz, s2_cxcz, s2_sxsz, s2_sxcz;
  logic signed [25:0] s2_hsx, s2_hcx;
  logic signed [17:0] s2_sxd;
  // stage 3: scale, divisor
  logic              s3_valid, s3_hdr;
  logic signed [7:0] s3_d;
  logic signed [9:0] s3_sz, s3_cz;
  logic signed [16:0] s3_hi;
  logic signed [14:0] s3_cxsz, s3_cxcz, s3_asxsz, s3_asxcz;
  logic signed [15:0] s3_hsx;
  logic signed [DW-1:0] s3_den;
  logic signed [26:0] den_sum;
  logic signed [DW-1:0] den_raw;
  // stage 4: second products
  logic              s4_valid, s4_hdr;
  logic signed [9:0] s4_sz, s4_cz;
  logic signed [25:0] s4_hsxsz, s4_hsxcz;
  logic signed [22:0] s4_cxszd, s4_cxczd;
  logic signed [31:0] s4_hisxsz, s4_hisxcz;
  logic [DW-1:0]     s4_dabs;
  logic              s4_dneg;
  // stage 5: numerators
  logic              s5_valid, s5_hdr;
  logic signed [23:0] s5_n [LANES];
  logic signed [15:0] s5_hisxsz, s5_hisxcz;
  logic [DW-1:0]     s5_dabs;
  logic              s5_dneg;
  logic signed [20:0] hsxsz, hsxcz;
  logic signed [31:0] cz32, sz32;
  logic signed [31:0] num [LANES];
  // stage 6: zoom products
  logic              s6_valid;
  logic signed [31:0] s6_prod [LANES];
  div_ctl_t          s6_ctl;
  // divider
  logic              dv [0:QW];
  div_lane_t         dl [0:QW][LANES];
  div_ctl_t          dc [0:QW];

  assign den_sum = s2_sxd + s2_hcx;
  assign den_raw = den_sum[26:5];
  assign hsxsz   = s4_hsxsz[25:5];
  assign hsxcz   = s4_hsxcz[25:5];
  assign cz32    = 32'(s4_cz);
  assign sz32    = 32'(s4_sz);
  assign num[0]  = hsxsz - (cz32 <<< NEAR_SHIFT) - s4_cxszd;
  assign num[1]  = s4_cxczd - (sz32 <<< NEAR_SHIFT) - hsxcz;
  assign num[2]  = hsxsz + cz32 * FAR_SCALE - s4_cxszd;
  assign num[3]  = sz32 * FAR_SCALE + s4_cxczd - hsxcz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      s6_valid  <= 1'b0;
      out_valid <= 1'b0;
      for (int s = 0; s <= QW; s++) dv[s] <= 1'b0;
    end else if (en) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      s5_valid  <= s4_valid;
      s6_valid  <= s5_valid;
      dv[0]     <= s6_valid;
      for (int s = 0; s < QW; s++) dv[s+1] <= dv[s];
      out_valid <= dv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_hdr <= row < RW'(HEADER_ROWS);
      s1_d   <= -$signed({1'b0, row});
      s1_sx  <= sine9(tilt_angle);
      s1_cx  <= sine9(tilt_angle + QUARTER_TURN);
      s1_sz  <= sine9(turn_angle);
      s1_cz  <= sine9(turn_angle + QUARTER_TURN);
      s1_hi  <= 17'(eye_height) + 17'(eye_offset);

      s2_hdr  <= s1_hdr;
      s2_d    <= s1_d;
      s2_sz   <= s1_sz;
      s2_cz   <= s1_cz;
      s2_hi   <= s1_hi;
      s2_cxsz <= s1_cx * s1_sz;
      s2_cxcz <= s1_cx * s1_cz;
      s2_sxsz <= s1_sx * s1_sz;
      s2_sxcz <= s1_sx * s1_cz;
      s2_hsx  <= eye_height * s1_sx;
      s2_hcx  <= eye_height * s1_cx;
      s2_sxd  <= s1_sx * s1_d;

      s3_hdr   <= s2_hdr;
      s3_d     <= s2_d;
      s3_sz    <= s2_sz;
      s3_cz    <= s2_cz;
      s3_hi    <= s2_hi;
      s3_cxsz  <= s2_cxsz[19:5];
      s3_cxcz  <= s2_cxcz[19:5];
      s3_asxsz <= s2_sxsz[19:5];
      s3_asxcz <= s2_sxcz[19:5];
      s3_hsx   <= s2_hsx[15:0];
      // zero divisor becomes one
      s3_den   <= (den_raw == '0) ? DW'(1) : den_raw;

      s4_hdr    <= s3_hdr;
      s4_sz     <= s3_sz;
      s4_cz     <= s3_cz;
      s4_hsxsz  <= s3_hsx * s3_sz;
      s4_hsxcz  <= s3_hsx * s3_cz;
      s4_cxszd  <= s3_cxsz * s3_d;
      s4_cxczd  <= s3_cxcz * s3_d;
      s4_hisxsz <= s3_asxsz * s3_hi;
      s4_hisxcz <= s3_asxcz * s3_hi;
      s4_dneg   <= s3_den[DW-1];
      s4_dabs   <= s3_den[DW-1] ? DW'(-s3_den) : s3_den;

      s5_hdr    <= s4_hdr;
      s5_dabs   <= s4_dabs;
      s5_dneg   <= s4_dneg;
      s5_hisxsz <= s4_hisxsz[23:8];
      s5_hisxcz <= s4_hisxcz[23:8];
      for (int k = 0; k < LANES; k++) s5_n[k] <= num[k][31:8];

      for (int k = 0; k < LANES; k++) s6_prod[k] <= s5_n[k] * zoom;
      s6_ctl.hdr  <= s5_hdr;
      s6_ctl.dabs <= s5_dabs;
      s6_ctl.neg  <= {LANES{s5_dneg}};
      s6_ctl.offu <= {pos_x[12:0], 3'b000} - s5_hisxsz;
      s6_ctl.offv <= {pos_y[12:0], 3'b000} + s5_hisxcz;

      // divider entry: magnitudes, quotient sign per lane
      dc[0].hdr  <= s6_ctl.hdr;
      dc[0].dabs <= s6_ctl.dabs;
      dc[0].offu <= s6_ctl.offu;
      dc[0].offv <= s6_ctl.offv;
      for (int k = 0; k < LANES; k++) begin
        dc[0].neg[k]  <= s6_ctl.neg[k] ^ s6_prod[k][31];
        dl[0][k].rem  <= '0;
        dl[0][k].word <= s6_prod[k][31] ? QW'(-s6_prod[k]) : s6_prod[k];
      end
      for (int s = 0; s < QW; s++) begin
        dc[s+1] <= dc[s];
        for (int k = 0; k < LANES; k++) dl[s+1][k] <= div_step(dl[s][k], dc[s].dabs);
      end
    end
  end

  logic [15:0] q [LANES];
  logic [15:0] u0, v0;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      q[k] = dc[QW].neg[k] ? 16'(-dl[QW][k].word[15:0]) : dl[QW][k].word[15:0];
    end
    u0 = q[0] + dc[QW].offu;
    v0 = q[1] + dc[QW].offv;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dc[QW].hdr) begin
        start_u <= HDR_START_U;
        start_v <= HDR_START_V;
        step_u  <= HDR_STEP;
        step_v  <= HDR_STEP;
      end else begin
        start_u <= u0;
        start_v <= v0;
        step_u  <= q[2] + dc[QW].offu - u0;
        step_v  <= q[3] + dc[QW].offv - v0;
      end
    end
  end

  `PFRV_AST_IMPL(a_stall_follows_out, out_valid && out_stall, in_stall)
  `PFRV_AST_NEXT(a_accept_enters, in_valid && !in_stall, s1_valid)
  `PFRV_AST_NEXT(a_div_drains, dv[QW] && !in_stall, out_valid)

endmodule

`default_nettype wire
